>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is asserted
`define CCAC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed");

// concurrent check that also holds through reset
`define CCAC_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("check failed");

`endif

>>> sv/ccac_pkg.sv
package ccac_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int OUT_W       = 32;
  localparam int CLUSTER_W   = 32;
  localparam int MIN_LEN_W   = 16;
  localparam int RATIO_W     = 16;
  localparam int FRAC_BITS   = 16;
  localparam int SCORE_W     = FRAC_BITS + 1;
  localparam int STEP_W      = $clog2(FRAC_BITS);
  localparam int PROD_W      = COUNT_WIDTH + RATIO_W;
  localparam int EXT_W       = COUNT_WIDTH + OUT_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t CNT_MAX = '1;
  localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEN   = 2'd0,
    CFG_GAP_LIMIT = 2'd1,
    CFG_SUSP      = 2'd2,
    CFG_SEVERE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_init;
    logic div_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic skip_div;
  } status_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input count_t v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return (e > EXT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : e[OUT_W-1:0];
  endfunction

endpackage

>>> sv/cluster_chain_anomaly_check_core.sv
// cluster chain anomaly checker
// input channel: one cluster number per transfer (in_valid_i / in_stall_o), chain_end_i
// marks the last cluster of a chain. items that do not end a chain are taken one per
// cycle while no chain summary is pending, and only update the running counters.
// the chain_end transfer starts the chain summary: the pairs x ratio product first,
// then a restoring divider that makes one fraction bit per cycle, then the load of the
// result register, which shows the result on out_valid_o. the divide is skipped when
// it is not needed (short chain, single cluster, or score saturated at 1.0).
// in_stall_o stays high from the chain_end transfer until the result register is loaded.
// output channel: one result per chain (out_valid_o / out_stall_i). the result register
// lets the next chain stream in while the last result waits; a stalled receiver only
// holds back the next chain's summary load, and the result holds steady until taken.
// config: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i, always ready;
// write only while no chain summary is pending.
// reset: asynchronous active low, chain counters cleared, config registers to defaults,
// no result pending.
module cluster_chain_anomaly_check_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ccac_pkg::CLUSTER_W-1:0]       cluster_number_i,
  input  logic                                 chain_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ccac_pkg::OUT_W-1:0]           repeat_total_o,
  output logic [ccac_pkg::OUT_W-1:0]           back_jump_total_o,
  output logic [ccac_pkg::OUT_W-1:0]           large_gap_total_o,
  output logic [ccac_pkg::SCORE_W-1:0]         fragmentation_q16_o,
  output logic                                 repeats_seen_o,
  output logic                                 back_jumps_flag_o,
  output logic                                 large_gaps_flag_o,
  output logic                                 fragmented_flag_o,
  output logic                                 corrupted_flag_o,
  output logic                                 analyzed_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ccac_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ccac_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ccac_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  ccac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .chain_end_i (chain_end_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  ccac_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .cluster_number_i    (cluster_number_i),
    .chain_end_i         (chain_end_i),
    .repeat_total_o      (repeat_total_o),
    .back_jump_total_o   (back_jump_total_o),
    .large_gap_total_o   (large_gap_total_o),
    .fragmentation_q16_o (fragmentation_q16_o),
    .repeats_seen_o      (repeats_seen_o),
    .back_jumps_flag_o   (back_jumps_flag_o),
    .large_gaps_flag_o   (large_gaps_flag_o),
    .fragmented_flag_o   (fragmented_flag_o),
    .corrupted_flag_o    (corrupted_flag_o),
    .analyzed_o          (analyzed_o)
  );

endmodule

>>> sv/ccac_ctrl.sv
module ccac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              chain_end_i,
  input  logic              out_stall_i,
  input  ccac_pkg::status_t status_i,
  output ccac_pkg::cmd_t    cmd_o,
  output logic              in_stall_o,
  output logic              out_valid_o
);
  import ccac_pkg::*;
  `include "assert_macros.svh"

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                load;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  // result register is free when empty or being drained this cycle
  assign load        = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign out_valid_d = load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  assign cmd_o.accept   = accept;
  assign cmd_o.div_init = (state_q == ST_MUL);
  assign cmd_o.div_step = (state_q == ST_DIV);
  assign cmd_o.load     = load;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && chain_end_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        step_d  = '0;
        state_d = status_i.skip_div ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CCAC_ASSERT(a_end_starts_calc, clk_i, rst_ni,
    (accept && chain_end_i) |=> (state_q == ST_MUL))
  `CCAC_ASSERT(a_div_exits_after_last_step, clk_i, rst_ni,
    (state_q == ST_DIV && step_q == STEP_LAST) |=> (state_q == ST_FIN))
  `CCAC_ASSERT(a_load_shows_result, clk_i, rst_ni,
    load |=> (out_valid_q && state_q == ST_IDLE))

endmodule

>>> sv/ccac_dp.sv
module ccac_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ccac_pkg::cmd_t                       cmd_i,
  output ccac_pkg::status_t                    status_o,
  input  logic                                 cfg_we_i,
  input  logic [ccac_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ccac_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [ccac_pkg::CLUSTER_W-1:0]       cluster_number_i,
  input  logic                                 chain_end_i,
  output logic [ccac_pkg::OUT_W-1:0]           repeat_total_o,
  output logic [ccac_pkg::OUT_W-1:0]           back_jump_total_o,
  output logic [ccac_pkg::OUT_W-1:0]           large_gap_total_o,
  output logic [ccac_pkg::SCORE_W-1:0]         fragmentation_q16_o,
  output logic                                 repeats_seen_o,
  output logic                                 back_jumps_flag_o,
  output logic                                 large_gaps_flag_o,
  output logic                                 fragmented_flag_o,
  output logic                                 corrupted_flag_o,
  output logic                                 analyzed_o
);
  import ccac_pkg::*;
  `include "assert_macros.svh"

  // configuration
  logic [MIN_LEN_W-1:0] min_len_q;
  logic [CLUSTER_W-1:0] gap_limit_q;
  logic [RATIO_W-1:0]   susp_q;
  logic [RATIO_W-1:0]   severe_q;

  // running chain state
  logic [CLUSTER_W-1:0] prev_q;
  count_t seen_q, rep_q, bj_q, lg_q, anom_q;
  count_t seen_nx, rep_nx, bj_nx, lg_nx, anom_nx;
  logic [CLUSTER_W-1:0] gap;
  logic is_rep, is_bj, is_lg;

  // snapshot of a finished chain
  count_t s_rep_q, s_bj_q, s_lg_q, s_anom_q, s_pairs_q;
  logic   s_an_q;

  // flag product and divider
  logic [PROD_W-1:0]    prod_q;
  count_t               rem_q;
  logic [FRAC_BITS-1:0] quot_q;
  logic [COUNT_WIDTH:0] rem_sh;
  logic                 rem_ge;

  // result
  logic [SCORE_W-1:0] score;
  logic bj_flag, lg_flag, fr_flag, rep_flag, pairs_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q   <= MIN_LEN_W'(2);
      gap_limit_q <= CLUSTER_W'(100);
      susp_q      <= RATIO_W'(6554);
      severe_q    <= RATIO_W'(19661);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_LEN:   min_len_q   <= cfg_data_i[MIN_LEN_W-1:0];
        CFG_GAP_LIMIT: gap_limit_q <= cfg_data_i[CLUSTER_W-1:0];
        CFG_SUSP:      susp_q      <= cfg_data_i[RATIO_W-1:0];
        CFG_SEVERE:    severe_q    <= cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // per-item compare against the previous cluster
  always_comb begin
    gap    = cluster_number_i - prev_q - CLUSTER_W'(1);
    is_rep = (seen_q != '0) && (cluster_number_i == prev_q);
    is_bj  = (seen_q != '0) && (cluster_number_i < prev_q);
    is_lg  = (seen_q != '0) && (cluster_number_i > prev_q) &&
             (gap != '0) && (gap >= gap_limit_q);
    seen_nx = sat_inc(seen_q);
    rep_nx  = is_rep ? sat_inc(rep_q) : rep_q;
    bj_nx   = is_bj ? sat_inc(bj_q) : bj_q;
    lg_nx   = is_lg ? sat_inc(lg_q) : lg_q;
    anom_nx = (is_rep || is_bj || is_lg) ? sat_inc(anom_q) : anom_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      seen_q <= '0;
      rep_q  <= '0;
      bj_q   <= '0;
      lg_q   <= '0;
      anom_q <= '0;
    end else if (cmd_i.accept) begin
      if (chain_end_i) begin
        prev_q <= '0;
        seen_q <= '0;
        rep_q  <= '0;
        bj_q   <= '0;
        lg_q   <= '0;
        anom_q <= '0;
      end else begin
        prev_q <= cluster_number_i;
        seen_q <= seen_nx;
        rep_q  <= rep_nx;
        bj_q   <= bj_nx;
        lg_q   <= lg_nx;
        anom_q <= anom_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && chain_end_i) begin
      s_rep_q   <= rep_nx;
      s_bj_q    <= bj_nx;
      s_lg_q    <= lg_nx;
      s_anom_q  <= anom_nx;
      s_pairs_q <= seen_nx - COUNT_WIDTH'(1);
      s_an_q    <= (seen_nx >= COUNT_WIDTH'(min_len_q));
    end
  end

  assign pairs_zero        = (s_pairs_q == '0);
  // score saturates at one when anomalies reach the pair count
  assign status_o.skip_div = !s_an_q || pairs_zero || (s_anom_q >= s_pairs_q);

  // restoring division of anomalies by pairs, one fraction bit per step
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, s_pairs_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      prod_q <= PROD_W'(s_pairs_q) * PROD_W'(susp_q);
      rem_q  <= s_anom_q;
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? rem_sh[COUNT_WIDTH-1:0] - s_pairs_q : rem_sh[COUNT_WIDTH-1:0];
      quot_q <= {quot_q[FRAC_BITS-2:0], rem_ge};
    end
  end

  always_comb begin
    if (pairs_zero) begin
      score = '0;
    end else if (s_anom_q >= s_pairs_q) begin
      score = SCORE_ONE;
    end else begin
      score = {1'b0, quot_q};
    end
    bj_flag  = !pairs_zero && ({s_bj_q, {FRAC_BITS{1'b0}}} > prod_q);
    lg_flag  = !pairs_zero && ({s_lg_q, {FRAC_BITS{1'b0}}} > prod_q);
    fr_flag  = score > SCORE_W'(severe_q);
    rep_flag = (s_rep_q != '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (s_an_q) begin
        repeat_total_o      <= to_out(s_rep_q);
        back_jump_total_o   <= to_out(s_bj_q);
        large_gap_total_o   <= to_out(s_lg_q);
        fragmentation_q16_o <= score;
        repeats_seen_o      <= rep_flag;
        back_jumps_flag_o   <= bj_flag;
        large_gaps_flag_o   <= lg_flag;
        fragmented_flag_o   <= fr_flag;
        corrupted_flag_o    <= rep_flag || bj_flag || lg_flag || fr_flag;
        analyzed_o          <= 1'b1;
      end else begin
        repeat_total_o      <= '0;
        back_jump_total_o   <= '0;
        large_gap_total_o   <= '0;
        fragmentation_q16_o <= '0;
        repeats_seen_o      <= 1'b0;
        back_jumps_flag_o   <= 1'b0;
        large_gaps_flag_o   <= 1'b0;
        fragmented_flag_o   <= 1'b0;
        corrupted_flag_o    <= 1'b0;
        analyzed_o          <= 1'b0;
      end
    end
  end

  `CCAC_ASSERT_NR(a_rem_below_divisor, clk_i,
    cmd_i.div_step |-> (rem_q < s_pairs_q))

endmodule
